### rtl/core/cfgp_pkg.sv
// shared types and constants for the configuration command byte parser
// depends on nothing; used by every file of the block but cfgp_stream_if
package cfgp_pkg;

	localparam int unsigned MAX_ADDR_BITS = 64;
	localparam int unsigned ADDR_W        = 64;
	localparam int unsigned LEN_W         = 7;
	localparam int unsigned TAKEN_W       = 3;

	typedef enum logic [1:0] {
		REPLY_OK      = 2'd0,
		REPLY_BAD_CMD = 2'd1,
		REPLY_BAD_ARG = 2'd2
	} reply_code_t;

	typedef enum logic [1:0] {
		CMD_SET_LEN  = 2'd0,
		CMD_SET_ADDR = 2'd1,
		CMD_SET_RATE = 2'd2
	} cmd_t;

	localparam logic [7:0] CMD_LAST = 8'(CMD_SET_RATE);

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [1:0]        reply_code;
		logic              clock_reinit;
		logic [ADDR_W-1:0] wake_address;
		logic [LEN_W-1:0]  address_bits;
		logic [7:0]        bit_rate_setting;
	} reply_item_t;

	typedef struct packed {
		logic        valid;
		reply_item_t item;
	} step_result_t;

endpackage

### rtl/core/cfgp_stream_if.sv
// valid/ready stream channel with a typed payload
// payload types come from cfgp_pkg
interface cfgp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/cfgp_core.sv
// parser state and the single-pass step logic for one byte
// depends on cfgp_pkg
module cfgp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  cfgp_pkg::rx_item_t    in_item,
	output cfgp_pkg::step_result_t result
);
	import cfgp_pkg::*;

	logic               arg_mode_q, arg_mode_n;
	cmd_t               pending_q, pending_n;
	logic [TAKEN_W-1:0] taken_q, taken_n;
	logic [ADDR_W-1:0]  addr_q, addr_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [7:0]         rate_q, rate_n;

	logic [7:0]         c;
	logic [TAKEN_W:0]   taken_p1;
	logic [LEN_W-1:0]   len_m1;
	logic [TAKEN_W:0]   needed;
	logic               emit;
	reply_code_t        code;
	logic               reinit;

	assign c        = in_item.rx_byte;
	assign taken_p1 = {1'b0, taken_q} + {{TAKEN_W{1'b0}}, 1'b1};
	assign len_m1   = len_q - LEN_W'(1);
	assign needed   = (len_q == '0) ? (TAKEN_W+1)'(1)
	                : {1'b0, len_m1[5:3]} + (TAKEN_W+1)'(1);

	always_comb begin
		arg_mode_n = arg_mode_q;
		pending_n  = pending_q;
		taken_n    = taken_q;
		addr_n     = addr_q;
		len_n      = len_q;
		rate_n     = rate_q;
		emit       = 1'b0;
		code       = REPLY_OK;
		reinit     = 1'b0;
		if (!arg_mode_q) begin
			if (c > CMD_LAST) begin
				emit = 1'b1;
				code = REPLY_BAD_CMD;
			end else begin
				pending_n  = cmd_t'(c[1:0]);
				arg_mode_n = 1'b1;
			end
		end else begin
			case (pending_q)
				CMD_SET_LEN: begin
					arg_mode_n = 1'b0;
					emit       = 1'b1;
					if (c > 8'(MAX_ADDR_BITS)) begin
						code = REPLY_BAD_ARG;
					end else begin
						len_n = c[LEN_W-1:0];
					end
				end
				CMD_SET_ADDR: begin
					if (taken_q == '0 && len_q == '0) begin
						addr_n     = '0;
						arg_mode_n = 1'b0;
						emit       = 1'b1;
						code       = REPLY_BAD_ARG;
					end else begin
						if (taken_q == '0) begin
							addr_n = {{(ADDR_W-8){1'b0}}, c};
						end else begin
							addr_n = {addr_q[ADDR_W-9:0], c};
						end
						if (taken_p1 == needed) begin
							taken_n    = '0;
							arg_mode_n = 1'b0;
							emit       = 1'b1;
						end else begin
							taken_n = taken_p1[TAKEN_W-1:0];
						end
					end
				end
				CMD_SET_RATE: begin
					rate_n     = c;
					arg_mode_n = 1'b0;
					emit       = 1'b1;
					reinit     = 1'b1;
				end
				default: begin
					// unreachable pending code: byte ignored
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_mode_q <= 1'b0;
			pending_q  <= CMD_SET_LEN;
			taken_q    <= '0;
			addr_q     <= '0;
			len_q      <= '0;
			rate_q     <= '0;
		end else if (fire) begin
			arg_mode_q <= arg_mode_n;
			pending_q  <= pending_n;
			taken_q    <= taken_n;
			addr_q     <= addr_n;
			len_q      <= len_n;
			rate_q     <= rate_n;
		end
	end

	assign result.valid                 = emit;
	assign result.item.reply_code       = code;
	assign result.item.clock_reinit     = reinit;
	assign result.item.wake_address     = addr_n;
	assign result.item.address_bits     = len_n;
	assign result.item.bit_rate_setting = rate_n;

endmodule

### rtl/core/config_command_byte_parser.sv
// top level: input register, parser core and reply register
// depends on cfgp_pkg, cfgp_stream_if and cfgp_core
//
//  channel | dir | payload                                              | transfer when
//  rx      | in  | rx_byte[7:0]                                         | rx.valid && rx.ready
//  reply   | out | reply_code, clock_reinit, wake_address, address_bits, | reply.valid &&
//          |     | bit_rate_setting                                     | reply.ready
//
// one byte per cycle unless a reply stalls; each reply comes from the registered core result
// the core updates its state in the cycle the byte leaves the input register
// arst_n clears the stage valids and all parser state
// a stalled reply holds the input register; rx stays ready while that stage is free
module config_command_byte_parser (
	input  logic          clk,
	input  logic          arst_n,
	cfgp_stream_if.sink   rx,
	cfgp_stream_if.source reply
);
	import cfgp_pkg::*;

	logic         valid_s1;
	rx_item_t     data_s1;
	logic         adv;
	step_result_t res;
	logic         out_valid_q;
	reply_item_t  out_data_q;

	assign adv      = valid_s1 && (!out_valid_q || reply.ready);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			data_s1 <= rx.data;
		end
	end

	cfgp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.in_item (data_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end else if (reply.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_data_q <= res.item;
		end
	end

	assign reply.valid = out_valid_q;
	assign reply.data  = out_data_q;

endmodule

### rtl/core/cfgp_checker.sv
// port-level assertions for the parser top level, with its bind
// depends on cfgp_pkg and config_command_byte_parser
module cfgp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rx_valid,
	input logic                 rx_ready,
	input logic                 reply_valid,
	input logic                 reply_ready,
	input cfgp_pkg::reply_item_t reply_data
);
	import cfgp_pkg::*;

	a_reply_hold: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && !reply_ready |=> reply_valid && $stable(reply_data))
		else $error("stalled reply changed");

	a_reply_code: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid |-> reply_data.reply_code == REPLY_OK
		|| reply_data.reply_code == REPLY_BAD_CMD
		|| reply_data.reply_code == REPLY_BAD_ARG)
		else $error("reply code out of range");

	a_reinit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply_data.clock_reinit |-> reply_data.reply_code == REPLY_OK)
		else $error("clock reinit without confirm");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid |-> reply_data.address_bits <= LEN_W'(MAX_ADDR_BITS))
		else $error("address length above maximum");

	a_reply_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(reply_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("reply without a byte transfer");

endmodule

bind config_command_byte_parser cfgp_checker u_cfgp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.reply_valid (reply.valid),
	.reply_ready (reply.ready),
	.reply_data  (reply.data)
);

### test/testbench.sv
// self-checking testbench for config_command_byte_parser
// drives received bytes, predicts every reply and compares each field on transfer
// depends on cfgp_pkg, cfgp_stream_if and the block's rtl
`timescale 1ns / 1ps

module testbench;
	import cfgp_pkg::*;

	typedef struct {
		logic              arg_mode;
		cmd_t              cmd;
		logic [TAKEN_W-1:0] taken;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [7:0]        rate;
	} parser_state_t;

	logic clk;
	logic arst_n;

	cfgp_stream_if #(.T(rx_item_t))    rx_ch ();
	cfgp_stream_if #(.T(reply_item_t)) reply_ch ();

	config_command_byte_parser u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.reply (reply_ch)
	);

	parser_state_t pred_state;
	parser_state_t gen_state;
	rx_item_t      pending_bytes[$];
	reply_item_t   expected_replies[$];
	reply_item_t   predicted;
	reply_item_t   want;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            item_count;
	int            mismatch_count;

	function automatic int address_bytes_needed(input logic [LEN_W-1:0] len);
		if (len == 0) begin
			return 1;
		end
		return ((int'(len) - 1) >> 3) + 1;
	endfunction

	function automatic bit parse_config_byte(inout parser_state_t s, input logic [7:0] b,
			output reply_item_t r);
		bit          has_reply;
		reply_code_t code;
		logic        reinit;
		int          taken_next;
		has_reply = 0;
		code      = REPLY_OK;
		reinit    = 0;
		r         = '0;
		if (!s.arg_mode) begin
			if (b > CMD_LAST) begin
				code      = REPLY_BAD_CMD;
				has_reply = 1;
			end else begin
				s.cmd      = cmd_t'(b[1:0]);
				s.arg_mode = 1;
			end
		end else begin
			case (s.cmd)
				CMD_SET_LEN: begin
					s.arg_mode = 0;
					has_reply  = 1;
					if (b > MAX_ADDR_BITS) begin
						code = REPLY_BAD_ARG;
					end else begin
						s.len = b[LEN_W-1:0];
					end
				end
				CMD_SET_ADDR: begin
					if (s.taken == 0) begin
						s.addr = '0;
					end else begin
						s.addr = s.addr << 8;
					end
					if (s.taken == 0 && s.len == 0) begin
						s.arg_mode = 0;
						code       = REPLY_BAD_ARG;
						has_reply  = 1;
					end else begin
						s.addr     = s.addr | ADDR_W'(b);
						taken_next = int'(s.taken) + 1;
						if (taken_next == address_bytes_needed(s.len)) begin
							s.taken    = '0;
							s.arg_mode = 0;
							has_reply  = 1;
						end else begin
							s.taken = TAKEN_W'(taken_next);
						end
					end
				end
				CMD_SET_RATE: begin
					s.rate     = b;
					s.arg_mode = 0;
					reinit     = 1;
					has_reply  = 1;
				end
				default: begin
				end
			endcase
		end
		if (has_reply) begin
			r.reply_code       = code;
			r.clock_reinit     = reinit;
			r.wake_address     = s.addr;
			r.address_bits     = s.len;
			r.bit_rate_setting = s.rate;
		end
		return has_reply;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		rx_item_t    it;
		reply_item_t unused;
		it.rx_byte = b;
		pending_bytes.push_back(it);
		void'(parse_config_byte(gen_state, b, unused));
		item_count++;
	endtask

	task automatic add_sequence();
		int kind;
		int pick;
		int n;
		while (gen_state.arg_mode) begin
			add_byte(8'($urandom_range(255)));
		end
		kind = $urandom_range(99);
		if (kind < 25) begin
			add_byte(8'(CMD_SET_LEN));
			pick = $urandom_range(99);
			if (pick < 45) begin
				add_byte(8'($urandom_range(1, 16)));
			end else if (pick < 70) begin
				add_byte(8'($urandom_range(17, 64)));
			end else if (pick < 80) begin
				add_byte(8'(MAX_ADDR_BITS));
			end else if (pick < 88) begin
				add_byte(8'd0);
			end else begin
				add_byte(8'($urandom_range(MAX_ADDR_BITS + 1, 255)));
			end
		end else if (kind < 55) begin
			add_byte(8'(CMD_SET_ADDR));
			n = address_bytes_needed(gen_state.len);
			repeat (n) add_byte(8'($urandom_range(255)));
		end else if (kind < 75) begin
			add_byte(8'(CMD_SET_RATE));
			add_byte(8'($urandom_range(255)));
		end else if (kind < 87) begin
			add_byte(8'($urandom_range(int'(CMD_LAST) + 1, 255)));
		end else begin
			repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic fill_random(input int count);
		int target;
		target = item_count + count;
		while (item_count < target) begin
			add_sequence();
		end
	endtask

	task automatic drain();
		int guard;
		while (pending_bytes.size() != 0 || rx_ch.valid) begin
			@(posedge clk);
		end
		guard = 0;
		while (expected_replies.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
	endtask

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// driver: predicts on each accepted transfer, then offers the next byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				if (parse_config_byte(pred_state, rx_ch.data.rx_byte, predicted)) begin
					expected_replies.push_back(predicted);
				end
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rx_ch.valid <= 1'b1;
					rx_ch.data  <= pending_bytes.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (reply_ch.valid && reply_ch.ready) begin
				if (expected_replies.size() == 0) begin
					$error("reply transfer with nothing expected");
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					if (reply_ch.data.reply_code !== want.reply_code) begin
						$error("reply_code expected %0d got %0d",
							want.reply_code, reply_ch.data.reply_code);
						mismatch_count++;
					end
					if (reply_ch.data.clock_reinit !== want.clock_reinit) begin
						$error("clock_reinit expected %0d got %0d",
							want.clock_reinit, reply_ch.data.clock_reinit);
						mismatch_count++;
					end
					if (reply_ch.data.wake_address !== want.wake_address) begin
						$error("wake_address expected %h got %h",
							want.wake_address, reply_ch.data.wake_address);
						mismatch_count++;
					end
					if (reply_ch.data.address_bits !== want.address_bits) begin
						$error("address_bits expected %0d got %0d",
							want.address_bits, reply_ch.data.address_bits);
						mismatch_count++;
					end
					if (reply_ch.data.bit_rate_setting !== want.bit_rate_setting) begin
						$error("bit_rate_setting expected %0d got %0d",
							want.bit_rate_setting, reply_ch.data.bit_rate_setting);
						mismatch_count++;
					end
				end
			end
			reply_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		rx_ch.valid    = 1'b0;
		rx_ch.data     = '0;
		reply_ch.ready = 1'b0;
		pred_state     = '{default: '0, cmd: CMD_SET_LEN};
		gen_state      = '{default: '0, cmd: CMD_SET_LEN};
		item_count     = 0;
		mismatch_count = 0;
		send_idle_pct  = 11;
		recv_idle_pct  = 50;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// bad commands, address before any length, length limits
		add_byte(8'(int'(CMD_LAST) + 1));
		add_byte(8'hff);
		add_byte(8'(CMD_SET_ADDR));
		add_byte(8'h5a);
		add_byte(8'(CMD_SET_LEN));
		add_byte(8'(MAX_ADDR_BITS + 1));
		add_byte(8'(CMD_SET_LEN));
		add_byte(8'(MAX_ADDR_BITS));
		// full width address, msb first
		add_byte(8'(CMD_SET_ADDR));
		add_byte(8'hff);
		add_byte(8'h00);
		add_byte(8'h80);
		add_byte(8'h01);
		add_byte(8'h7f);
		add_byte(8'hfe);
		add_byte(8'h55);
		add_byte(8'haa);
		// short length with unmasked address bytes
		add_byte(8'(CMD_SET_LEN));
		add_byte(8'd12);
		add_byte(8'(CMD_SET_ADDR));
		add_byte(8'hff);
		add_byte(8'hff);
		add_byte(8'(CMD_SET_RATE));
		add_byte(8'h00);
		add_byte(8'(CMD_SET_RATE));
		add_byte(8'hff);
		add_byte(8'(CMD_SET_LEN));
		add_byte(8'h00);
		fill_random(160);
		drain();

		send_idle_pct = 50;
		recv_idle_pct = 11;
		fill_random(185);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_random(185);
		drain();

		if (expected_replies.size() != 0) begin
			$error("replies never arrived: %0d", expected_replies.size());
			mismatch_count += expected_replies.size();
		end
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
rtl/core/cfgp_pkg.sv
rtl/core/cfgp_stream_if.sv
rtl/core/cfgp_core.sv
rtl/core/config_command_byte_parser.sv
rtl/core/cfgp_checker.sv
test/testbench.sv
